>>> src/complex_accumulator_alu_core_macros.svh
// Assertion macros for the complex accumulator ALU.
// Taken in by the modules that assert; relies on clk_i and rst_ni in scope.
`ifndef COMPLEX_ACCUMULATOR_ALU_CORE_MACROS_SVH
`define COMPLEX_ACCUMULATOR_ALU_CORE_MACROS_SVH

// plain property, checked outside reset
`define CACC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication, checked outside reset
`define CACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CACC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cacc_pkg.sv
// Package for the complex accumulator ALU: opcodes, status codes, sequencer
// states and helper types. No dependencies.
`default_nettype none

package cacc_pkg;

  localparam int unsigned CaccFracBits = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 65;
  localparam int unsigned UnitW = 66;

  localparam logic signed [DataW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic [2:0] {
    OP_LOAD = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_CONJ = 3'd5,
    OP_MOD  = 3'd6,
    OP_CMP  = 3'd7
  } cacc_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } cacc_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROD,
    S_DRAIN,
    S_MUL_FIN,
    S_DIV_CHK,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_STORE,
    S_SQ_INIT,
    S_SQ_STEP,
    S_FIN
  } cacc_state_e;

  typedef enum logic [1:0] {
    SEL_AR,
    SEL_AI,
    SEL_BR,
    SEL_BI
  } cacc_sel_e;

  typedef enum logic [1:0] {
    TGT_RE,
    TGT_IM,
    TGT_DEN
  } cacc_tgt_e;

  // one product of the multiply/accumulate schedule
  typedef struct packed {
    cacc_sel_e sel_a;
    cacc_sel_e sel_b;
    cacc_tgt_e tgt;
    logic      neg;
  } cacc_uop_t;

  // clamped 32-bit value and its saturation flag
  typedef struct packed {
    logic                    sat;
    logic signed [DataW-1:0] val;
  } cacc_clamp_t;

endpackage

`default_nettype wire

>>> src/complex_accumulator_alu_core.sv
// Complex accumulator ALU in signed fixed point (FRAC_BITS fraction bits).
// Channels: input item {opcode_i, operand_real_i, operand_imag_i} on
// in_valid_i/in_ready_o; result item {result_real_o, result_imag_o,
// magnitude_o, equal_flag_o, status_o} on out_valid_o/out_ready_i.
// One item is worked at a time; in_ready_o is high only while the sequencer
// is idle. A result sits in an output register, so the next item is taken
// while the previous result still waits.
// Work per item: load, add, sub, conj and compare go from idle straight to the
// finish state; mul runs four products through one 32x32 multiplier;
// modulus runs two products, then a 32-step bit-serial square root;
// div runs six products, then two 32-step restoring divisions sharing
// one 66-bit subtractor. Divide by zero ends after the products.
// Reset clears the accumulator to zero and empties the output register.
// When the receiver stalls, a finished item waits in the sequencer until
// the output register frees up; the accumulator updates as it is handed over.
`default_nettype none

module complex_accumulator_alu_core import cacc_pkg::*; #(
  parameter int unsigned FRAC_BITS = CaccFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic signed [31:0] operand_real_i,
  input  wire logic signed [31:0] operand_imag_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      result_real_o,
  output logic signed [31:0]      result_imag_o,
  output logic [31:0]             magnitude_o,
  output logic                    equal_flag_o,
  output logic [1:0]              status_o
);

  localparam int unsigned NumW  = 64 + FRAC_BITS;
  localparam int unsigned HighW = NumW - 32;
  localparam int unsigned PadW  = UnitW - HighW;

  cacc_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        half_q, half_d;
  cacc_op_e    op_q, op_d;
  logic signed [31:0] acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [31:0] br_q, br_d, bi_q, bi_d;
  logic signed [SumW-1:0] s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic signed [63:0] p_q, p_d;
  logic        pv_q, pv_d;
  cacc_tgt_e   ptgt_q, ptgt_d;
  logic        pneg_q, pneg_d;
  logic [UnitW-1:0] rem_q, rem_d;
  logic [31:0] low_q, low_d, quo_q, quo_d, root_q, root_d;
  logic        qneg_q, qneg_d, ovf_q, ovf_d;
  logic [63:0] xs_q, xs_d;
  logic signed [31:0] nr_q, nr_d, ni_q, ni_d;
  logic [31:0] mag_q, mag_d;
  logic        eq_q, eq_d, sat_q, sat_d, divz_q, divz_d;
  logic        ovalid_q, ovalid_d;
  logic signed [31:0] ore_q, ore_d, oim_q, oim_d;
  logic [31:0] omag_q, omag_d;
  logic        oeq_q, oeq_d;
  cacc_status_e ost_q, ost_d;

  // shared subtractor
  logic [UnitW-1:0] unit_a, unit_b, unit_diff;
  logic             unit_ge;
  // shared multiplier
  cacc_uop_t          uop;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  // accumulate adder
  logic signed [SumW-1:0] acc_in, acc_add, acc_sum;
  // divider setup
  logic signed [SumW-1:0] num;
  logic [63:0]            nmag;
  logic [NumW-1:0]        nwide;
  logic [UnitW-1:0]       r2;
  logic [2:0]             last_step;
  cacc_clamp_t            cl_re, cl_im;
  logic [63:0]            mag_re, mag_im;

  function automatic cacc_clamp_t from_mag(logic neg, logic [63:0] mag);
    cacc_clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.sat = 1'b1;
        r.val = QMin;
      end else begin
        r.val = 32'(32'd0 - mag[31:0]);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = QMax;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic cacc_clamp_t clamp33(logic signed [32:0] v);
    cacc_clamp_t r;
    r.sat = (v[32] != v[31]);
    if (v[32] != v[31]) begin
      r.val = v[32] ? QMin : QMax;
    end else begin
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs65(logic signed [SumW-1:0] v);
    logic [SumW-1:0] m;
    m = v[SumW-1] ? SumW'(-v) : v;
    return m[63:0];
  endfunction

  // product schedule per opcode and step
  function automatic cacc_uop_t uop_of(cacc_op_e op, logic [2:0] step);
    cacc_uop_t u;
    u = '{sel_a: SEL_AR, sel_b: SEL_AR, tgt: TGT_DEN, neg: 1'b0};
    unique case (op)
      OP_MUL: begin
        unique case (step)
          3'd0:    u = '{sel_a: SEL_AR, sel_b: SEL_BR, tgt: TGT_RE, neg: 1'b0};
          3'd1:    u = '{sel_a: SEL_AI, sel_b: SEL_BI, tgt: TGT_RE, neg: 1'b1};
          3'd2:    u = '{sel_a: SEL_AR, sel_b: SEL_BI, tgt: TGT_IM, neg: 1'b0};
          default: u = '{sel_a: SEL_AI, sel_b: SEL_BR, tgt: TGT_IM, neg: 1'b0};
        endcase
      end
      OP_DIV: begin
        unique case (step)
          3'd0:    u = '{sel_a: SEL_BR, sel_b: SEL_BR, tgt: TGT_DEN, neg: 1'b0};
          3'd1:    u = '{sel_a: SEL_BI, sel_b: SEL_BI, tgt: TGT_DEN, neg: 1'b0};
          3'd2:    u = '{sel_a: SEL_AR, sel_b: SEL_BR, tgt: TGT_RE, neg: 1'b0};
          3'd3:    u = '{sel_a: SEL_AI, sel_b: SEL_BI, tgt: TGT_RE, neg: 1'b0};
          3'd4:    u = '{sel_a: SEL_AI, sel_b: SEL_BR, tgt: TGT_IM, neg: 1'b0};
          default: u = '{sel_a: SEL_AR, sel_b: SEL_BI, tgt: TGT_IM, neg: 1'b1};
        endcase
      end
      default: begin
        if (step == 3'd0) begin
          u = '{sel_a: SEL_AR, sel_b: SEL_AR, tgt: TGT_DEN, neg: 1'b0};
        end else begin
          u = '{sel_a: SEL_AI, sel_b: SEL_AI, tgt: TGT_DEN, neg: 1'b0};
        end
      end
    endcase
    return u;
  endfunction

  function automatic logic signed [31:0] pick(cacc_sel_e s, logic signed [31:0] ar,
                                              logic signed [31:0] ai, logic signed [31:0] br,
                                              logic signed [31:0] bi);
    logic signed [31:0] r;
    unique case (s)
      SEL_AR:  r = ar;
      SEL_AI:  r = ai;
      SEL_BR:  r = br;
      default: r = bi;
    endcase
    return r;
  endfunction

  // datapath pieces
  assign uop   = uop_of(op_q, cnt_q[2:0]);
  assign mul_a = pick(uop.sel_a, acc_re_q, acc_im_q, br_q, bi_q);
  assign mul_b = pick(uop.sel_b, acc_re_q, acc_im_q, br_q, bi_q);
  assign prod  = mul_a * mul_b;

  always_comb begin
    unique case (ptgt_q)
      TGT_RE:  acc_in = s0_q;
      TGT_IM:  acc_in = s1_q;
      default: acc_in = s2_q;
    endcase
  end
  assign acc_add = pneg_q ? -SumW'(p_q) : SumW'(p_q);
  assign acc_sum = acc_in + acc_add;

  assign unit_diff = unit_a - unit_b;
  assign unit_ge   = ~unit_diff[UnitW-1];

  assign num   = half_q ? s1_q : s0_q;
  assign nmag  = abs65(num);
  assign nwide = {nmag, {FRAC_BITS{1'b0}}};

  assign mag_re = abs65(s0_q) >> FRAC_BITS;
  assign mag_im = abs65(s1_q) >> FRAC_BITS;
  assign cl_re  = from_mag(s0_q[SumW-1], mag_re);
  assign cl_im  = from_mag(s1_q[SumW-1], mag_im);

  always_comb begin
    unique case (op_q)
      OP_MUL:  last_step = 3'd3;
      OP_DIV:  last_step = 3'd5;
      default: last_step = 3'd1;
    endcase
  end

  // divider and square root steps feed the subtractor from here
  always_comb begin
    r2 = '0;
    if (state_q == S_SQ_STEP) begin
      r2 = {rem_q[UnitW-3:0], xs_q[63:62]};
    end else begin
      r2 = {rem_q[UnitW-2:0], low_q[31]};
    end
  end

  always_comb begin
    cacc_clamp_t c;
    state_d  = state_q;
    cnt_d    = cnt_q;
    half_d   = half_q;
    op_d     = op_q;
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    br_d     = br_q;
    bi_d     = bi_q;
    s0_d     = s0_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    p_d      = p_q;
    pv_d     = 1'b0;
    ptgt_d   = ptgt_q;
    pneg_d   = pneg_q;
    rem_d    = rem_q;
    low_d    = low_q;
    quo_d    = quo_q;
    root_d   = root_q;
    qneg_d   = qneg_q;
    ovf_d    = ovf_q;
    xs_d     = xs_q;
    nr_d     = nr_q;
    ni_d     = ni_q;
    mag_d    = mag_q;
    eq_d     = eq_q;
    sat_d    = sat_q;
    divz_d   = divz_q;
    ovalid_d = ovalid_q;
    ore_d    = ore_q;
    oim_d    = oim_q;
    omag_d   = omag_q;
    oeq_d    = oeq_q;
    ost_d    = ost_q;
    unit_a   = '0;
    unit_b   = '0;
    c        = '0;
    in_ready_o = (state_q == S_IDLE);

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    // finish the pending product
    if (pv_q) begin
      unique case (ptgt_q)
        TGT_RE:  s0_d = acc_sum;
        TGT_IM:  s1_d = acc_sum;
        default: s2_d = acc_sum;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = cacc_op_e'(opcode_i);
          br_d   = operand_real_i;
          bi_d   = operand_imag_i;
          s0_d   = '0;
          s1_d   = '0;
          s2_d   = '0;
          cnt_d  = '0;
          half_d = 1'b0;
          sat_d  = 1'b0;
          divz_d = 1'b0;
          eq_d   = 1'b0;
          mag_d  = '0;
          nr_d   = acc_re_q;
          ni_d   = acc_im_q;
          state_d = S_FIN;
          unique case (cacc_op_e'(opcode_i))
            OP_LOAD: begin
              nr_d = operand_real_i;
              ni_d = operand_imag_i;
            end
            OP_ADD, OP_SUB: begin
              if (cacc_op_e'(opcode_i) == OP_ADD) begin
                c = clamp33(33'(acc_re_q) + 33'(operand_real_i));
                nr_d = c.val;
                sat_d = c.sat;
                c = clamp33(33'(acc_im_q) + 33'(operand_imag_i));
              end else begin
                c = clamp33(33'(acc_re_q) - 33'(operand_real_i));
                nr_d = c.val;
                sat_d = c.sat;
                c = clamp33(33'(acc_im_q) - 33'(operand_imag_i));
              end
              ni_d  = c.val;
              sat_d = sat_d | c.sat;
            end
            OP_CONJ: begin
              c = clamp33(33'sd0 - 33'(acc_im_q));
              ni_d  = c.val;
              sat_d = c.sat;
            end
            OP_CMP: begin
              eq_d = (acc_re_q == operand_real_i) && (acc_im_q == operand_imag_i);
            end
            default: begin
              state_d = S_PROD;
            end
          endcase
        end
      end
      S_PROD: begin
        p_d    = prod;
        pv_d   = 1'b1;
        ptgt_d = uop.tgt;
        pneg_d = uop.neg;
        if (cnt_q[2:0] == last_step) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_DRAIN: begin
        unique case (op_q)
          OP_MUL:  state_d = S_MUL_FIN;
          OP_DIV:  state_d = S_DIV_CHK;
          default: state_d = S_SQ_INIT;
        endcase
      end
      S_MUL_FIN: begin
        nr_d    = cl_re.val;
        ni_d    = cl_im.val;
        sat_d   = cl_re.sat | cl_im.sat;
        state_d = S_FIN;
      end
      S_DIV_CHK: begin
        if (s2_q == '0) begin
          divz_d  = 1'b1;
          state_d = S_FIN;
        end else begin
          half_d  = 1'b0;
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        // integer part beyond 32 bits means the quotient clamps
        unit_a  = {{PadW{1'b0}}, nwide[NumW-1:32]};
        unit_b  = {2'b00, s2_q[63:0]};
        ovf_d   = unit_ge;
        rem_d   = unit_a;
        low_d   = nwide[31:0];
        qneg_d  = num[SumW-1] && (nmag != '0);
        quo_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        unit_a = r2;
        unit_b = {2'b00, s2_q[63:0]};
        rem_d  = unit_ge ? unit_diff : r2;
        quo_d  = {quo_q[30:0], unit_ge};
        low_d  = {low_q[30:0], 1'b0};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        if (ovf_q) begin
          c.sat = 1'b1;
          c.val = qneg_q ? QMin : QMax;
        end else begin
          c = from_mag(qneg_q, {32'd0, quo_q});
        end
        sat_d = sat_q | c.sat;
        if (half_q) begin
          ni_d    = c.val;
          state_d = S_FIN;
        end else begin
          nr_d    = c.val;
          half_d  = 1'b1;
          state_d = S_DIV_INIT;
        end
      end
      S_SQ_INIT: begin
        xs_d    = s2_q[63:0];
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        unit_a = r2;
        unit_b = {32'd0, root_q, 2'b01};
        rem_d  = unit_ge ? unit_diff : r2;
        root_d = {root_q[30:0], unit_ge};
        xs_d   = {xs_q[61:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          mag_d   = {root_q[30:0], unit_ge};
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ore_d    = nr_q;
          oim_d    = ni_q;
          omag_d   = mag_q;
          oeq_d    = eq_q;
          priority if (divz_q) begin
            ost_d = ST_DIVZ;
          end else if (sat_q) begin
            ost_d = ST_SAT;
          end else begin
            ost_d = ST_OK;
          end
          acc_re_d = nr_q;
          acc_im_d = ni_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      half_q   <= 1'b0;
      pv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      half_q   <= half_d;
      pv_q     <= pv_d;
      ovalid_q <= ovalid_d;
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    br_q   <= br_d;
    bi_q   <= bi_d;
    s0_q   <= s0_d;
    s1_q   <= s1_d;
    s2_q   <= s2_d;
    p_q    <= p_d;
    ptgt_q <= ptgt_d;
    pneg_q <= pneg_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quo_q  <= quo_d;
    root_q <= root_d;
    qneg_q <= qneg_d;
    ovf_q  <= ovf_d;
    xs_q   <= xs_d;
    nr_q   <= nr_d;
    ni_q   <= ni_d;
    mag_q  <= mag_d;
    eq_q   <= eq_d;
    sat_q  <= sat_d;
    divz_q <= divz_d;
    ore_q  <= ore_d;
    oim_q  <= oim_d;
    omag_q <= omag_d;
    oeq_q  <= oeq_d;
    ost_q  <= ost_d;
  end

  assign out_valid_o   = ovalid_q;
  assign result_real_o = ore_q;
  assign result_imag_o = oim_q;
  assign magnitude_o   = omag_q;
  assign equal_flag_o  = oeq_q;
  assign status_o      = ost_q;

`include "complex_accumulator_alu_core_macros.svh"

  `CACC_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `CACC_ASSERT_IMP(a_result_is_acc, out_valid_o, (result_real_o == acc_re_q) && (result_imag_o == acc_im_q), "result differs from accumulator")
  `CACC_ASSERT_IMP(a_flags_exclusive, out_valid_o, !(equal_flag_o && (magnitude_o != '0)), "equal flag with magnitude")
  `CACC_ASSERT(a_status_code, status_o != 2'd3, "undefined status code")

endmodule

`default_nettype wire

>>> sim/tb_complex_accumulator_alu_core.sv
// Self-checking testbench for complex_accumulator_alu_core: a directed table, then
// random items under three idle patterns, each result checked against a local model
// or the typed rows of the table. Depends on cacc_pkg and the core RTL only.
`timescale 1ns / 1ps
`default_nettype none

module tb_complex_accumulator_alu_core;
  import cacc_pkg::*;

  localparam int NDIR    = 20;
  localparam int NRAND   = 2000;
  localparam int LIMIT   = 1000000;
  localparam int HOLD_AT = NDIR + 1500;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    logic               eq;
    logic [1:0]         st;
  } alu_res_t;

  typedef struct {
    cacc_op_e           op;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    bit                 typed;
    alu_res_t           res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] opcode_i = '0;
  logic signed [31:0] operand_real_i = '0;
  logic signed [31:0] operand_imag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] result_real_o, result_imag_o;
  logic [31:0] magnitude_o;
  logic equal_flag_o;
  logic [1:0] status_o;

  complex_accumulator_alu_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .operand_real_i,
    .operand_imag_i, .out_valid_o, .out_ready_i, .result_real_o, .result_imag_o,
    .magnitude_o, .equal_flag_o, .status_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic signed [31:0] acc_re = '0, acc_im = '0;
  alu_res_t expected_q[$];
  dir_row_t dir_tab[NDIR];
  int n_taken = 0;
  int n_err = 0;
  int snd_pct = 29;
  int rcv_pct = 64;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  bit stim_done = 1'b0;

  function automatic cacc_clamp_t clamp_q(logic signed [95:0] v);
    cacc_clamp_t c;
    c.sat = 1'b0;
    if (v > QMax) begin
      c.sat = 1'b1;
      c.val = QMax;
    end else if (v < QMin) begin
      c.sat = 1'b1;
      c.val = QMin;
    end else begin
      c.val = v[31:0];
    end
    return c;
  endfunction

  function automatic logic [31:0] isqrt(logic [63:0] x);
    logic [63:0] rem, res, b;
    rem = x;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[31:0];
  endfunction

  // give a magnitude, truncated toward zero by the caller, the sign of s
  function automatic logic signed [95:0] signed_mag(logic signed [95:0] s,
                                                    logic [95:0] mag);
    logic signed [95:0] t;
    t = mag;
    return (s < 0) ? -t : t;
  endfunction

  // computes the result item and advances the accumulator copy
  function automatic alu_res_t alu_predict(logic [2:0] op, logic signed [31:0] br32,
                                           logic signed [31:0] bi32);
    alu_res_t r;
    logic signed [95:0] ar, ai, br, bi, sr, si, den;
    logic [95:0] mr, mi;
    cacc_clamp_t cr, ci;
    bit sat;
    ar = acc_re;
    ai = acc_im;
    br = br32;
    bi = bi32;
    r = '0;
    r.re = acc_re;
    r.im = acc_im;
    sat = 1'b0;
    cr = '0;
    ci = '0;
    case (op)
      OP_LOAD: begin
        r.re = br32;
        r.im = bi32;
      end
      OP_ADD, OP_SUB: begin
        cr = clamp_q(op == OP_ADD ? ar + br : ar - br);
        ci = clamp_q(op == OP_ADD ? ai + bi : ai - bi);
        sat = cr.sat | ci.sat;
        r.re = cr.val;
        r.im = ci.val;
      end
      OP_MUL: begin
        sr = ar * br - ai * bi;
        si = ar * bi + ai * br;
        mr = (sr < 0) ? -sr : sr;
        mi = (si < 0) ? -si : si;
        cr = clamp_q(signed_mag(sr, mr >> CaccFracBits));
        ci = clamp_q(signed_mag(si, mi >> CaccFracBits));
        sat = cr.sat | ci.sat;
        r.re = cr.val;
        r.im = ci.val;
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DIVZ;
        end else begin
          sr = ar * br + ai * bi;
          si = ai * br - ar * bi;
          mr = (sr < 0) ? -sr : sr;
          mi = (si < 0) ? -si : si;
          cr = clamp_q(signed_mag(sr, (mr << CaccFracBits) / den));
          ci = clamp_q(signed_mag(si, (mi << CaccFracBits) / den));
          sat = cr.sat | ci.sat;
          r.re = cr.val;
          r.im = ci.val;
        end
      end
      OP_CONJ: begin
        ci = clamp_q(-ai);
        sat = ci.sat;
        r.im = ci.val;
      end
      OP_MOD: begin
        mr = (ar < 0) ? -ar : ar;
        mi = (ai < 0) ? -ai : ai;
        r.mag = isqrt(mr[63:0] * mr[63:0] + mi[63:0] * mi[63:0]);
      end
      default: r.eq = (acc_re == br32) && (acc_im == bi32);
    endcase
    if (sat) r.st = ST_SAT;
    acc_re = r.re;
    acc_im = r.im;
    return r;
  endfunction

  // accepted items and results, sampled before this edge's updates land
  always @(posedge clk_i) begin
    alu_res_t e, got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        e = alu_predict(opcode_i, operand_real_i, operand_imag_i);
        if (n_taken < NDIR && dir_tab[n_taken].typed) e = dir_tab[n_taken].res;
        expected_q.push_back(e);
        n_taken <= n_taken + 1;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{result_real_o, result_imag_o, magnitude_o, equal_flag_o, status_o};
        if (expected_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result item re=%h im=%h", got.re, got.im);
        end else begin
          e = expected_q.pop_front();
          if (got !== e) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp re=%h im=%h mag=%h eq=%b st=%0d, got re=%h im=%h mag=%h eq=%b st=%0d",
                       e.re, e.im, e.mag, e.eq, e.st,
                       got.re, got.im, got.mag, got.eq, got.st);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk_i) begin
    if (!hold_done && n_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_pct);
    end
  end

  initial begin
    int cyc;
    for (cyc = 0; cyc < LIMIT; cyc++) @(posedge clk_i);
    $display("complex_accumulator_alu_core regression: fail");
    $finish;
  end

  task automatic send_item(logic [2:0] op, logic signed [31:0] br, logic signed [31:0] bi);
    while ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    operand_real_i <= br;
    operand_imag_i <= bi;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [31:0] rand_operand();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return $signed($urandom_range(8 << 16)) - (4 << 16);
      7: case ($urandom_range(4))
           0: return QMax;
           1: return QMin;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      8: return $signed($urandom_range(255)) - 128;
      default: return 0;
    endcase
  endfunction

  initial begin
    int k;
    logic [2:0] op;
    dir_tab = '{
      '{OP_CMP,  0, 0, 1, '{32'sd0, 32'sd0, 32'd0, 1'b1, ST_OK}},
      '{OP_MOD,  5, 7, 1, '{32'sd0, 32'sd0, 32'd0, 1'b0, ST_OK}},
      '{OP_DIV,  0, 0, 1, '{32'sd0, 32'sd0, 32'd0, 1'b0, ST_DIVZ}},
      '{OP_LOAD, QMax, QMin, 1, '{QMax, QMin, 32'd0, 1'b0, ST_OK}},
      '{OP_CONJ, 3, 3, 1, '{QMax, QMax, 32'd0, 1'b0, ST_SAT}},
      '{OP_ADD,  1, 1, 1, '{QMax, QMax, 32'd0, 1'b0, ST_SAT}},
      '{OP_MOD,  0, 0, 0, '0},
      '{OP_SUB,  QMin, QMin, 1, '{QMax, QMax, 32'd0, 1'b0, ST_SAT}},
      '{OP_MUL,  ONE, 0, 0, '0},
      '{OP_LOAD, QMin, QMin, 1, '{QMin, QMin, 32'd0, 1'b0, ST_OK}},
      '{OP_MUL,  QMin, QMin, 0, '0},
      '{OP_LOAD, ONE, 0, 0, '0},
      '{OP_DIV,  QMin, QMax, 0, '0},
      '{OP_DIV,  1, 0, 0, '0},
      '{OP_LOAD, 3 * ONE, 4 * ONE, 0, '0},
      '{OP_MOD,  0, 0, 1, '{3 * ONE, 4 * ONE, 32'd327680, 1'b0, ST_OK}},
      '{OP_CMP,  3 * ONE, 4 * ONE, 1, '{3 * ONE, 4 * ONE, 32'd0, 1'b1, ST_OK}},
      '{OP_CMP,  3 * ONE, 5, 1, '{3 * ONE, 4 * ONE, 32'd0, 1'b0, ST_OK}},
      '{OP_MUL,  0, ONE, 0, '0},
      '{OP_DIV,  0, 0, 0, '0}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (k = 0; k < NDIR; k++) send_item(dir_tab[k].op, dir_tab[k].br, dir_tab[k].bi);
    for (k = 0; k < NRAND; k++) begin
      if (k == NRAND / 3) begin
        snd_pct = 64;
        rcv_pct = 29;
      end else if (k == 2 * NRAND / 3) begin
        snd_pct = 0;
        rcv_pct = 0;
      end
      if (k == NRAND / 2) begin
        // hold the input until every result has drained
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_q.size() != 0);
      end
      op = ($urandom_range(99) < 12) ? OP_LOAD : 3'($urandom_range(7, 1));
      send_item(op, rand_operand(), rand_operand());
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (100) @(posedge clk_i);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("complex_accumulator_alu_core regression: pass");
    end else begin
      $display("complex_accumulator_alu_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
